FILE: rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Request and response payloads, operation codes and fixed constants of the
// LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CFG_W   = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [CFG_W-1:0]   CAPACITY_RESET = 5'd16;
  localparam logic [FIELD_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                       operation;
    logic signed [FIELD_W-1:0]  lookup_key;
    logic signed [FIELD_W-1:0]  write_value;
  } req_t;

  typedef struct packed {
    logic                       hit;
    logic signed [FIELD_W-1:0]  read_value;
    logic                       evicted;
  } rsp_t;

  // Lookup outcome handed from the directory to the datapath.
  typedef struct packed {
    logic hit;
    logic evict;
  } dir_status_t;

endpackage

FILE: rtl/lkvc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lkvc_dir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_dir
// Key directory: valid bits, keys, recency ranks and occupancy. Parallel key
// compare, victim and free-slot pick, and the rank update of one request.
// ----------------------------------------------------------------------------
module lkvc_dir #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [KEY_BITS-1:0]                    key,
  input  logic                                   is_put,
  input  logic [lkvc_pkg::CFG_W-1:0]             capacity,
  input  logic                                   update_en,
  output lkvc_pkg::dir_status_t                  status,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] slot_idx
);

  localparam int unsigned IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned RW    = IW;
  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW    = (OCC_W > lkvc_pkg::CFG_W) ? OCC_W : lkvc_pkg::CFG_W;

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [RW-1:0]          rank_r   [MAX_ENTRIES];
  logic [RW-1:0]          rank_nxt [MAX_ENTRIES];
  logic [KEY_BITS-1:0]    key_r    [MAX_ENTRIES];
  logic [OCC_W-1:0]       occ_r, occ_nxt;

  logic [MAX_ENTRIES-1:0] match, lru, free_slots, first_free, ins_oh;
  logic [IW-1:0]          hit_idx, ins_idx;
  logic [RW-1:0]          hit_rank, lru_rank;
  logic [CW-1:0]          cap_ext, eff_cap;
  logic                   hit, full, evict, insert;

  // Clamp capacity into 1..MAX_ENTRIES.
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Ranks of valid entries are always 0..occupancy-1, so the victim is the
  // one entry whose rank equals occupancy-1.
  assign lru_rank = RW'(occ_r - OCC_W'(1));
  assign full     = CW'(occ_r) >= eff_cap;

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]      = valid_r[i] && (key_r[i] == key);
      lru[i]        = valid_r[i] && (rank_r[i] == lru_rank);
      free_slots[i] = !valid_r[i];
      // Keys in the directory are distinct: at most one match.
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
    end
  end

  assign first_free = free_slots & (~free_slots + MAX_ENTRIES'(1));
  assign hit        = |match;
  assign evict      = is_put && !hit && full;
  assign insert     = is_put && !hit;
  assign ins_oh     = evict ? lru : first_free;

  always_comb begin
    ins_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (ins_oh[i]) begin
        ins_idx = ins_idx | IW'(i);
      end
    end
  end

  assign slot_idx     = hit ? hit_idx : ins_idx;
  assign status.hit   = hit;
  assign status.evict = evict;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (update_en) begin
        if (hit) begin
          // Promote: entries more recent than the hit age by one.
          if (match[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end else if (is_put) begin
          if (ins_oh[i]) begin
            valid_nxt[i] = 1'b1;
            rank_nxt[i]  = '0;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end
      end
    end
    if (update_en && insert && !evict) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (update_en && insert && ins_oh[i]) begin
        key_r[i] <= key;
      end
    end
  end

endmodule

FILE: rtl/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Path: a request accepted into the request register moves on into the
//   response register, from which it can be taken.
// Throughput: one request per cycle while the response is not stalled, set
//   by the directory compare-and-update, whose new state the next request looks up.
// Reset: valid bits, ranks and occupancy clear and capacity returns to 16;
//   no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lkvc_pkg::req_t               in_data,
  // response channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkvc_pkg::rsp_t               out_data,
  // capacity register
  input  logic                         cfg_we,
  input  logic [lkvc_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned FW = lkvc_pkg::FIELD_W;

  // Request register.
  logic           s1_valid_r, s1_valid_nxt;
  lkvc_pkg::req_t s1_req_r;
  // Response register: flags only, a hit value comes from the RAM read port.
  logic           out_valid_r, out_valid_nxt;
  logic           hit_r, evicted_r, get_hit_r, get_miss_r;
  logic [lkvc_pkg::CFG_W-1:0] capacity_r;

  logic                  advance, accept, is_put, is_get;
  lkvc_pkg::dir_status_t dir_status;
  logic [IW-1:0]         slot_idx;
  logic [KEY_BITS+FW-1:0]   key_ext;
  logic [VALUE_BITS+FW-1:0] wval_ext;
  logic [FW+VALUE_BITS-1:0] rval_ext;
  logic [VALUE_BITS-1:0]    ram_rdata;

  // Advance the request into the response register whenever that register is
  // empty or being drained this cycle; hold the request otherwise.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign is_put = (s1_req_r.operation == lkvc_pkg::OP_PUT);
  assign is_get = (s1_req_r.operation == lkvc_pkg::OP_GET);

  // Fit the 32-bit fields to the stored key and value widths.
  assign key_ext  = {{KEY_BITS{1'b0}}, s1_req_r.lookup_key};
  assign wval_ext = {{VALUE_BITS{1'b0}}, s1_req_r.write_value};

  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= lkvc_pkg::CAPACITY_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_data;
    end
    if (advance) begin
      hit_r      <= dir_status.hit;
      evicted_r  <= dir_status.evict;
      get_hit_r  <= is_get && dir_status.hit;
      get_miss_r <= is_get && !dir_status.hit;
    end
  end

  // Directory: compare, pick slot, update ranks on the advancing request.
  lkvc_dir #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key_ext[KEY_BITS-1:0]),
    .is_put    (is_put),
    .capacity  (capacity_r),
    .update_en (advance),
    .status    (dir_status),
    .slot_idx  (slot_idx)
  );

  // Value store: a put writes its slot, a get hit reads it. The read is
  // enabled only on advance, so read data holds while the response stalls.
  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (advance && is_put),
    .waddr (slot_idx),
    .wdata (wval_ext[VALUE_BITS-1:0]),
    .re    (advance && is_get && dir_status.hit),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  assign rval_ext = {{FW{1'b0}}, ram_rdata};

  // Drive the response: stored value on a get hit, all ones on a get miss,
  // zero for a put.
  always_comb begin
    out_data.hit     = hit_r;
    out_data.evicted = evicted_r;
    if (get_hit_r) begin
      out_data.read_value = rval_ext[FW-1:0];
    end else if (get_miss_r) begin
      out_data.read_value = lkvc_pkg::MISS_VALUE;
    end else begin
      out_data.read_value = '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU key-value cache. A queue of pending get and
// put requests feeds a clocked driver. Each accepted request runs through a
// local recency model that predicts hit, read value and eviction. A clocked
// monitor compares every response with the oldest prediction. Phases switch
// the capacity register while the cache is idle, from directed corners to
// long random runs over small key pools that keep hits and evictions frequent.
// ----------------------------------------------------------------------------
module testbench;
  import lkvc_pkg::*;

  localparam int SLOTS          = 16;
  localparam int ITEMS_PER_SET  = 128;
  localparam int IDLE_PCT       = 12;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  req_t            in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rsp_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Requests waiting for the driver and responses predicted for the monitor.
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  // Local copy of the cache directory, advanced once per accepted request.
  logic              slot_live[SLOTS];
  logic [FIELD_W-1:0] slot_key[SLOTS];
  logic [FIELD_W-1:0] slot_val[SLOTS];
  int unsigned       slot_age[SLOTS];
  int unsigned       live_count;
  logic [CFG_W-1:0]  cap_setting = CAPACITY_RESET;

  int unsigned reqs_queued  = 0;
  int unsigned reqs_taken   = 0;
  int unsigned rsps_seen    = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_mark    = 300;
  logic        req_taken    = 1'b0;
  rsp_t        want_rsp;

  lru_key_value_cache_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Recency model
  // --------------------------------------------------------------------------

  // Clamp the register: zero behaves as one slot, anything above the store
  // size behaves as the full store.
  function automatic int unsigned usable_slots(input logic [CFG_W-1:0] setting);
    int unsigned s;
    s = 32'(setting);
    if (s == 0) return 1;
    if (s > SLOTS) return SLOTS;
    return s;
  endfunction

  // Move slot s to the front; every live slot that was newer ages by one.
  function automatic void make_newest(input int s);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Predict the response of one request and update the directory copy.
  function automatic rsp_t lru_access(input req_t r);
    rsp_t        res;
    int          found;
    int          slot;
    int          i;
    int unsigned oldest;
    res    = '0;
    found  = -1;
    slot   = -1;
    oldest = 0;
    for (i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_live[i] && slot_key[i] == r.lookup_key) found = i;
    end
    res.hit = (found >= 0);
    if (r.operation == OP_GET) begin
      if (found >= 0) begin
        res.read_value = slot_val[found];
        make_newest(found);
      end else begin
        res.read_value = MISS_VALUE;
      end
      return res;
    end
    if (found >= 0) begin
      slot_val[found] = r.write_value;
      make_newest(found);
      return res;
    end
    // New key: when full (or over a lowered capacity) drop the oldest entry
    // and reuse its slot, else take the lowest free slot.
    if (live_count >= usable_slots(cap_setting) && live_count > 0) begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && (slot < 0 || slot_age[i] >= oldest)) begin
          oldest = slot_age[i];
          slot   = i;
        end
      end
      slot_live[slot] = 1'b0;
      live_count--;
      res.evicted = 1'b1;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (slot < 0 && !slot_live[i]) slot = i;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) slot_age[i]++;
    end
    slot_live[slot] = 1'b1;
    slot_key[slot]  = r.lookup_key;
    slot_val[slot]  = r.write_value;
    slot_age[slot]  = 0;
    live_count++;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: advance on acceptance, idle at random outside the quiet
  // window, hold the payload while stalled.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_reqs.size() > 0 &&
          ((reqs_taken >= 500 && reqs_taken < 650) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Take the request on the handshake edge and predict its response.
  always @(posedge clk) begin
    req_taken <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      expected_rsps.push_back(lru_access(in_data));
      reqs_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Response side: random stall, a quiet window, and now and then a long
  // hold-off so the pipeline backs up into the request channel.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left == 0 && rsps_seen >= hold_mark) begin
      hold_left = HOLD_CYCLES;
      hold_mark = hold_mark + 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rsps_seen >= 500 && rsps_seen < 650) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Check every accepted response against the oldest prediction.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) begin
      rsps_seen++;
      if (expected_rsps.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: response with nothing expected: hit=%0b value=%h evicted=%0b",
                   $realtime, out_data.hit, out_data.read_value, out_data.evicted);
        mismatches++;
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (out_data.hit !== want_rsp.hit || out_data.read_value !== want_rsp.read_value ||
            out_data.evicted !== want_rsp.evicted) begin
          if (mismatches < REPORT_LIMIT) begin
            $write("%0t: response %0d mismatch: expected hit=%0b value=%h evicted=%0b, ",
                   $realtime, rsps_seen, want_rsp.hit, want_rsp.read_value,
                   want_rsp.evicted);
            $display("got hit=%0b value=%h evicted=%0b",
                     out_data.hit, out_data.read_value, out_data.evicted);
          end
          mismatches++;
        end
      end
    end
  end

  // Drop the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic issue(input logic op, input logic [FIELD_W-1:0] key,
                       input logic [FIELD_W-1:0] val);
    req_t r;
    r.operation   = op;
    r.lookup_key  = key;
    r.write_value = val;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Hold off until every queued request is taken and answered, then let the
  // pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (reqs_taken != reqs_queued || expected_rsps.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we      <= 1'b0;
    cap_setting = v;
  endtask

  logic [CFG_W-1:0]   cap_plan[10]    = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5,
                                          5'd2, 5'd16, 5'd8, 5'd3, 5'd12};
  logic [FIELD_W-1:0] corner_keys[4]  = '{32'h8000_0000, 32'h7FFF_FFFF,
                                          32'hFFFF_FFFF, 32'h0000_0000};
  logic [FIELD_W-1:0] key_pool[24];
  logic [FIELD_W-1:0] pick_key;
  int unsigned        pool_span;

  initial begin
    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      slot_age[i]  = 0;
    end
    live_count = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners at reset capacity: miss on empty, extreme keys and values,
    // hits, an update in place, a miss on a partly filled cache.
    issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
    issue(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    issue(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    issue(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    issue(OP_GET, 32'h5555_5555, 32'h0000_0000);
    wait_drained();

    // Capacity lowered below occupancy: each new key evicts exactly one.
    write_capacity(5'd2);
    issue(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    issue(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    issue(OP_GET, 32'h8000_0000, 32'h0000_0000);
    issue(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Zero capacity behaves as a single slot.
    write_capacity(5'd0);
    issue(OP_PUT, 32'h1357_9BDF, 32'h0000_0001);
    issue(OP_GET, 32'h1357_9BDF, 32'h0000_0000);
    issue(OP_PUT, 32'h2468_ACE0, 32'hFFFF_FFFE);
    issue(OP_GET, 32'h1357_9BDF, 32'h0000_0000);
    wait_drained();

    // Random sets: mostly keys from a small pool sized just past the
    // capacity, so hits, updates and evictions all recur; the rest are
    // fresh random keys that almost always miss.
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      foreach (key_pool[i])
        key_pool[i] = ($urandom_range(0, 7) == 0) ? corner_keys[$urandom_range(0, 3)]
                                                  : $urandom;
      pool_span = usable_slots(cap_plan[p]) + 3;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if ($urandom_range(0, 99) < 80) pick_key = key_pool[$urandom_range(0, pool_span - 1)];
        else pick_key = $urandom;
        issue(($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET, pick_key, $urandom);
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_dir.sv
rtl/lru_key_value_cache_top.sv
tb/sv/testbench.sv
